// File: rtl/pncs_pkg.sv
package pncs_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;

  localparam int CHAN_W  = 8;
  localparam int RGB_W   = 3 * CHAN_W;
  localparam int WGT_W   = 9;
  localparam int TGT_W   = 10;
  localparam int GSUM_W  = 15;
  localparam int GPROD_W = 30;
  localparam int DIFF_W  = 16;
  localparam int SQ_W    = 32;
  localparam int DIST_W  = 34;

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_BLEND = 2'd1;
  localparam logic [1:0] REQ_GREY  = 2'd2;

  localparam logic REG_WEIGHT_ON    = 1'b0;
  localparam logic REG_WEIGHT_UNDER = 1'b1;

  localparam logic [WGT_W-1:0] WEIGHT_RESET = 9'd128;

  // channel weights, R G B: used for the grey target and for the distance
  localparam logic [5:0] COEF [3] = '{6'd30, 6'd59, 6'd11};

  // x / 100 == (x * 20972) >> 21 for x < 43690
  localparam logic [GPROD_W-1:0] GREY_RECIP = 30'd20972;
  localparam int                 GREY_SHIFT = 21;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_SCAN,
    ST_HOLD
  } pncs_state_t;

  function automatic logic [CHAN_W-1:0] get_chan(input logic [RGB_W-1:0] rgb, input int c);
    get_chan = rgb[RGB_W-1-CHAN_W*c -: CHAN_W];
  endfunction

endpackage

// File: rtl/pncs_in_if.sv
interface pncs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] index_a;
  logic [7:0] index_b;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output req_type, output index_a, output index_b,
                  output red, output green, output blue, input ready);
  modport sink (input valid, input req_type, input index_a, input index_b,
                input red, input green, input blue, output ready);
endinterface

// File: rtl/pncs_out_if.sv
interface pncs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] best_index;

  modport source (output valid, output best_index, input ready);
  modport sink (input valid, input best_index, output ready);
endinterface

// File: rtl/palette_nearest_color_search.sv
// Nearest palette color search. The palette (PALETTE_ENTRIES RGB entries) lives in a
// single-port-read synchronous RAM; per-entry valid flags make every entry read as black
// after reset, so no clearing pass is needed. A write transaction (req_type 0) writes
// index_a's entry. A blend or grey query forms its target through states RD_B, MUL, SUM
// and DIV, then streams the palette through the read port one entry per cycle into a
// four-stage distance pipeline, and presents its result after that pipeline drains. One
// query is in flight at a time; a new transaction is accepted while the last result
// waits on out_ch. Weights sit at APB address 0 (weight_on) and 4 (weight_under).
module palette_nearest_color_search
  import pncs_pkg::*;
#(
  parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  pncs_in_if.sink           in_ch,
  pncs_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int                 IDX_W    = $clog2(PALETTE_ENTRIES);
  localparam logic [8:0]         NUM_ENT  = 9'(PALETTE_ENTRIES);
  localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

  pncs_state_t state_r, state_nxt;

  logic [WGT_W-1:0] w_on_r, w_under_r;

  logic [RGB_W-1:0]       mem [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] ent_vld_r;
  logic [RGB_W-1:0]       rd_data_r;
  logic                   rd_vld_r;
  logic [IDX_W-1:0]       rd_addr;

  logic in_acc, a_in_ok, b_in_ok, mem_we, query_acc;

  logic             a_ok_r, b_ok_r, grey_r;
  logic [IDX_W-1:0] b_addr_r;
  logic [RGB_W-1:0] a_rgb_r;
  logic [RGB_W-1:0] b_rgb;
  logic [RGB_W-1:0] cand_rgb;

  logic [16:0]        pa_r [3];
  logic [16:0]        pb_r [3];
  logic [13:0]        gw_r [3];
  logic [GSUM_W-1:0]  gsum_r;
  logic [GPROD_W-1:0] gprod;
  logic [TGT_W-1:0]   t_r [3];

  logic             iss_r, iss_nxt;
  logic [IDX_W-1:0] iss_idx_r, iss_idx_nxt;

  logic              m_v_r, p1_v_r, p2_v_r, p3_v_r;
  logic [IDX_W-1:0]  m_idx_r, p1_idx_r, p2_idx_r, p3_idx_r;
  logic [DIFF_W-1:0] p1_d_r [3];
  logic [SQ_W-1:0]   p2_sq_r [3];
  logic [DIST_W-1:0] p3_sum_r;
  logic [DIST_W-1:0] least_r;
  logic [IDX_W-1:0]  best_r;

  logic             out_vld_r, out_vld_nxt;
  logic [IDX_W-1:0] out_best_r, out_best_nxt;
  logic             out_load;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_on_r    <= WEIGHT_RESET;
      w_under_r <= WEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_WEIGHT_UNDER) begin
        w_under_r <= pwdata[WGT_W-1:0];
      end else begin
        w_on_r <= pwdata[WGT_W-1:0];
      end
    end
  end

  assign prdata = {23'd0, (paddr[2] == REG_WEIGHT_UNDER) ? w_under_r : w_on_r};
  assign pready = 1'b1;

  // input side
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign a_in_ok     = ({1'b0, in_ch.index_a} < NUM_ENT);
  assign b_in_ok     = ({1'b0, in_ch.index_b} < NUM_ENT);
  assign mem_we      = in_acc && (in_ch.req_type == REQ_WRITE) && a_in_ok;
  assign query_acc   = in_acc &&
                       ((in_ch.req_type == REQ_BLEND) || (in_ch.req_type == REQ_GREY));

  always_comb begin
    case (state_r)
      ST_IDLE: rd_addr = a_in_ok ? in_ch.index_a[IDX_W-1:0] : '0;
      ST_RD_B: rd_addr = b_addr_r;
      default: rd_addr = iss_idx_r;
    endcase
  end

  // palette RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[in_ch.index_a[IDX_W-1:0]] <= {in_ch.red, in_ch.green, in_ch.blue};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (mem_we) begin
        ent_vld_r[in_ch.index_a[IDX_W-1:0]] <= 1'b1;
      end
      rd_vld_r <= ent_vld_r[rd_addr];
    end
  end

  // target formation
  assign b_rgb    = (rd_vld_r && b_ok_r) ? rd_data_r : '0;
  assign cand_rgb = rd_vld_r ? rd_data_r : '0;
  assign gprod    = GPROD_W'(gsum_r) * GREY_RECIP;

  always_ff @(posedge clk) begin
    if (query_acc) begin
      a_ok_r   <= a_in_ok;
      b_ok_r   <= b_in_ok;
      b_addr_r <= b_in_ok ? in_ch.index_b[IDX_W-1:0] : '0;
      grey_r   <= (in_ch.req_type == REQ_GREY);
    end
    if (state_r == ST_RD_B) begin
      a_rgb_r <= (rd_vld_r && a_ok_r) ? rd_data_r : '0;
    end
    if (state_r == ST_MUL) begin
      for (int c = 0; c < 3; c++) begin
        pa_r[c] <= 17'(get_chan(a_rgb_r, c)) * 17'(w_on_r);
        pb_r[c] <= 17'(get_chan(b_rgb, c)) * 17'(w_under_r);
        gw_r[c] <= 14'(get_chan(a_rgb_r, c)) * 14'(COEF[c]);
      end
    end
    if (state_r == ST_SUM) begin
      gsum_r <= GSUM_W'(gw_r[0]) + GSUM_W'(gw_r[1]) + GSUM_W'(gw_r[2]);
      if (!grey_r) begin
        for (int c = 0; c < 3; c++) begin
          t_r[c] <= TGT_W'((18'(pa_r[c]) + 18'(pb_r[c])) >> 8);
        end
      end
    end
    if ((state_r == ST_DIV) && grey_r) begin
      for (int c = 0; c < 3; c++) begin
        t_r[c] <= TGT_W'(gprod >> GREY_SHIFT);
      end
    end
  end

  // distance pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r  <= 1'b0;
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else begin
      m_v_r  <= (state_r == ST_SCAN) && iss_r;
      p1_v_r <= m_v_r;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [TGT_W-1:0] ce;
    logic [TGT_W-1:0] df;
    m_idx_r  <= iss_idx_r;
    p1_idx_r <= m_idx_r;
    p2_idx_r <= p1_idx_r;
    p3_idx_r <= p2_idx_r;
    for (int c = 0; c < 3; c++) begin
      ce = TGT_W'(get_chan(cand_rgb, c));
      df = (ce > t_r[c]) ? (ce - t_r[c]) : (t_r[c] - ce);
      p1_d_r[c]  <= DIFF_W'(df) * DIFF_W'(COEF[c]);
      p2_sq_r[c] <= SQ_W'(p1_d_r[c]) * SQ_W'(p1_d_r[c]);
    end
    p3_sum_r <= DIST_W'(p2_sq_r[0]) + DIST_W'(p2_sq_r[1]) + DIST_W'(p2_sq_r[2]);
    if (p3_v_r && ((p3_idx_r == '0) || (p3_sum_r < least_r))) begin
      least_r <= p3_sum_r;
      best_r  <= p3_idx_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    iss_nxt      = iss_r;
    iss_idx_nxt  = iss_idx_r;
    out_load     = 1'b0;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_best_nxt = out_best_r;
    case (state_r)
      ST_IDLE: begin
        if (query_acc) state_nxt = ST_RD_B;
      end
      ST_RD_B: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_DIV;
      ST_DIV: begin
        state_nxt   = ST_SCAN;
        iss_nxt     = 1'b1;
        iss_idx_nxt = '0;
      end
      ST_SCAN: begin
        if (iss_r) begin
          if (iss_idx_r == LAST_IDX) begin
            iss_nxt = 1'b0;
          end else begin
            iss_idx_nxt = iss_idx_r + IDX_W'(1);
          end
        end else if (!m_v_r && !p1_v_r && !p2_v_r && !p3_v_r) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!out_vld_r || out_ch.ready) begin
          out_load     = 1'b1;
          out_vld_nxt  = 1'b1;
          out_best_nxt = best_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      iss_r     <= 1'b0;
      iss_idx_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iss_r     <= iss_nxt;
      iss_idx_r <= iss_idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_best_r <= out_best_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.best_index = 8'(out_best_r);

endmodule

// File: rtl/pncs_checker.sv
module pncs_checker
  import pncs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pncs_in_if.sink     in_ch,
  pncs_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata
);

  logic query_acc;

  assign query_acc = in_ch.valid && in_ch.ready &&
                     ((in_ch.req_type == REQ_BLEND) || (in_ch.req_type == REQ_GREY));

  // one query in flight: busy right after a query transaction
  a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc |=> !in_ch.ready)
    else $error("input ready after query transaction");

  // a query never answers in the next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    query_acc && !out_ch.valid |=> !out_ch.valid)
    else $error("result too early after query");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.best_index))
    else $error("result dropped or changed while stalled");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=>
      (paddr[2] != $past(paddr[2])) || (prdata == {23'd0, $past(pwdata[8:0])}))
    else $error("weight readback mismatch");

endmodule

bind palette_nearest_color_search pncs_checker u_pncs_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .in_ch   (in_ch),
  .out_ch  (out_ch),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata)
);
